### src/queue_id_allocator_with_owner_map_defines.svh
// Assertion macros for the RTL file that carries assertions.
// Both expect i_clk and i_rst_n in scope.
`ifndef QUEUE_ID_ALLOCATOR_WITH_OWNER_MAP_DEFINES_SVH
`define QUEUE_ID_ALLOCATOR_WITH_OWNER_MAP_DEFINES_SVH

// same-cycle implication
`define QIDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QIDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/qida_pkg.sv
package qida_pkg;

    localparam int CLIENT_W = 31;
    localparam int QID_W    = 7;
    localparam int QCNT_W   = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        KIND_GET   = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_DISC  = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 2'd0,
        STS_NO_QUEUE   = 2'd1,
        STS_TABLE_FULL = 2'd2,
        STS_NOT_FOUND  = 2'd3
    } t_status;

    // what the shared scan unit is looking for
    typedef enum logic [1:0] {
        SM_CLEAR     = 2'd0,
        SM_FREE_Q    = 2'd1,
        SM_FREE_SLOT = 2'd2,
        SM_FIND      = 2'd3
    } t_scan_mode;

    typedef struct packed {
        logic       start;
        t_scan_mode mode;
    } t_scan_ctl;

    typedef struct packed {
        logic issue;
        logic done;
        logic found;
    } t_scan_sts;

    typedef enum logic [3:0] {
        ST_INIT      = 4'd0,
        ST_CLEAR     = 4'd1,
        ST_IDLE      = 4'd2,
        ST_GET_Q     = 4'd3,
        ST_GET_SLOT  = 4'd4,
        ST_GET_FIND  = 4'd5,
        ST_FREE_FIND = 4'd6,
        ST_DISC_FIND = 4'd7,
        ST_QRY_DATA  = 4'd8
    } t_state;

endpackage

### src/qida_ram.sv
module qida_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/qida_scan.sv
// Shared scan unit: walks addresses 0..limit-1 against registered-read RAMs,
// one address issued per cycle, and stops at the first matching entry.
module qida_scan #(
    parameter int ADDR_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qida_pkg::t_scan_ctl           i_ctl,
    input  logic [ADDR_W-1:0]             i_limit,
    input  logic                          i_used_bit,
    input  logic                          i_valid_bit,
    input  logic [qida_pkg::CLIENT_W-1:0] i_client_rd,
    input  logic [qida_pkg::CLIENT_W-1:0] i_client_key,
    output qida_pkg::t_scan_sts           o_sts,
    output logic [ADDR_W-1:0]             o_addr,
    output logic [ADDR_W-1:0]             o_idx
);
    import qida_pkg::*;

    logic              r_run, n_run;
    logic              r_chk_vld, n_chk_vld;
    t_scan_mode        r_mode, n_mode;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ADDR_W-1:0] r_chk_idx, n_chk_idx;
    logic              issue;
    logic              hit;
    logic              chk_hit;
    logic              done;

    always_comb begin
        unique case (r_mode)
            SM_CLEAR:     hit = 1'b0;
            SM_FREE_Q:    hit = !i_used_bit;
            SM_FREE_SLOT: hit = !i_valid_bit;
            SM_FIND:      hit = i_valid_bit && (i_client_rd == i_client_key);
        endcase
    end

    assign issue   = r_run && (r_addr < i_limit);
    assign chk_hit = r_run && r_chk_vld && hit;
    // finished on a hit, or once the last issued word has been checked
    assign done    = r_run && (chk_hit || (!r_chk_vld && !issue));

    always_comb begin
        n_run     = r_run;
        n_chk_vld = r_chk_vld;
        n_mode    = r_mode;
        n_addr    = r_addr;
        n_chk_idx = r_chk_idx;
        if (i_ctl.start) begin
            n_run     = 1'b1;
            n_chk_vld = 1'b0;
            n_mode    = i_ctl.mode;
            n_addr    = '0;
        end else if (done) begin
            n_run     = 1'b0;
            n_chk_vld = 1'b0;
        end else if (r_run) begin
            n_chk_vld = issue;
            n_chk_idx = r_addr;
            if (issue) begin
                n_addr = r_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_chk_vld <= 1'b0;
            r_mode    <= SM_CLEAR;
        end else begin
            r_run     <= n_run;
            r_chk_vld <= n_chk_vld;
            r_mode    <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_chk_idx <= n_chk_idx;
    end

    assign o_sts.issue = issue;
    assign o_sts.done  = done;
    assign o_sts.found = chk_hit;
    assign o_addr      = r_addr;
    assign o_idx       = r_chk_idx;

endmodule

### src/queue_id_allocator_with_owner_map.sv
// Queue number allocator with a client-to-queue owner table.
// Command channel: start/busy; a word is taken at an edge with start high and
// busy low. i_kind selects get, free, disconnect or query.
// Result channel: o_strobe marks the one cycle in which o_status,
// o_queue_id_out and o_used are valid; the receiver cannot stall it.
// Config channel: i_cfg_valid/o_cfg_ready/i_cfg_data writes queue_count;
// ready is always high, write only while the block is idle.
// Get, free and disconnect run through one scan unit stepping one RAM address per
// cycle: get scans the active queues and then the owner table, and once more the
// owner table when it is full; free and disconnect scan the owner table. A free
// with its queue out of range answers without a scan (busy stays low). Query
// reads the bitmap without a scan. A scan ends early on its first match.
// Reset: a clearing pass zeroes the used bitmap and owner valid bits, one
// address per cycle over max(QUEUE_SLOTS, OWNER_ENTRIES) addresses, busy
// high meanwhile. queue_count resets to 0.
`include "queue_id_allocator_with_owner_map_defines.svh"
module queue_id_allocator_with_owner_map #(
    parameter int QUEUE_SLOTS   = 128,
    parameter int OWNER_ENTRIES = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_kind,
    input  logic [qida_pkg::CLIENT_W-1:0] i_client_id,
    input  logic [qida_pkg::QID_W-1:0]    i_queue_id,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qida_pkg::QCNT_W-1:0]   i_cfg_data,
    output logic                          o_strobe,
    output logic [qida_pkg::STATUS_W-1:0] o_status,
    output logic [qida_pkg::QID_W-1:0]    o_queue_id_out,
    output logic                          o_used
);
    import qida_pkg::*;

    localparam int UAW  = $clog2(QUEUE_SLOTS);
    localparam int OAW  = $clog2(OWNER_ENTRIES);
    localparam int MAXE = (QUEUE_SLOTS > OWNER_ENTRIES) ? QUEUE_SLOTS : OWNER_ENTRIES;
    localparam int SW   = $clog2(MAXE + 1);
    localparam int LW   = (SW > QCNT_W) ? SW : QCNT_W;
    localparam int OW   = CLIENT_W + UAW;

    t_state                r_state, n_state;
    logic [QCNT_W-1:0]     r_queue_count;
    logic [CLIENT_W-1:0]   r_client, n_client;
    logic [QID_W-1:0]      r_qin, n_qin;
    logic [UAW-1:0]        r_q, n_q;
    logic                  r_strobe, n_strobe;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [QID_W-1:0]      r_qout, n_qout;
    logic                  r_used, n_used;

    logic [LW-1:0]         lim_w;
    logic [SW-1:0]         lim;
    logic                  qin_ok;
    logic                  rqin_ok;
    logic [UAW-1:0]        own_q;
    logic                  own_q_ok;
    t_kind                 kind;

    t_scan_ctl             scan_ctl;
    t_scan_sts             scan_sts;
    logic [SW-1:0]         scan_limit;
    logic [SW-1:0]         scan_addr;
    logic [SW-1:0]         scan_idx;

    logic                  used_we;
    logic [UAW-1:0]        used_waddr;
    logic                  used_wdata;
    logic [UAW-1:0]        used_raddr;
    logic                  used_rd;
    logic                  valid_we;
    logic [OAW-1:0]        valid_waddr;
    logic                  valid_wdata;
    logic                  valid_rd;
    logic                  own_we;
    logic [OW-1:0]         own_wdata;
    logic [OW-1:0]         own_rd;

    // active queue count, capped at the bitmap size
    always_comb begin
        if (LW'(r_queue_count) > LW'(QUEUE_SLOTS)) begin
            lim_w = LW'(QUEUE_SLOTS);
        end else begin
            lim_w = LW'(r_queue_count);
        end
    end

    assign lim      = SW'(lim_w);
    assign qin_ok   = LW'(i_queue_id) < lim_w;
    assign rqin_ok  = LW'(r_qin) < lim_w;
    assign own_q    = own_rd[UAW-1:0];
    assign own_q_ok = LW'(own_q) < lim_w;
    assign kind     = t_kind'(i_kind);
    assign busy     = (r_state != ST_IDLE);

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_count <= '0;
        end else if (i_cfg_valid) begin
            r_queue_count <= i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                n_state = ST_CLEAR;
            end
            ST_CLEAR: begin
                if (scan_sts.done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (kind)
                        KIND_GET:   n_state = ST_GET_Q;
                        KIND_FREE:  n_state = qin_ok ? ST_FREE_FIND : ST_IDLE;
                        KIND_DISC:  n_state = ST_DISC_FIND;
                        KIND_QUERY: n_state = ST_QRY_DATA;
                    endcase
                end
            end
            ST_GET_Q: begin
                if (scan_sts.done) begin
                    n_state = scan_sts.found ? ST_GET_SLOT : ST_IDLE;
                end
            end
            ST_GET_SLOT: begin
                if (scan_sts.done) begin
                    n_state = scan_sts.found ? ST_IDLE : ST_GET_FIND;
                end
            end
            ST_GET_FIND, ST_FREE_FIND, ST_DISC_FIND: begin
                if (scan_sts.done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QRY_DATA: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // outputs, RAM writes, scan control
    always_comb begin
        n_client      = r_client;
        n_qin         = r_qin;
        n_q           = r_q;
        n_strobe      = 1'b0;
        n_status      = STS_OK;
        n_qout        = '0;
        n_used        = 1'b0;
        scan_ctl      = '{start: 1'b0, mode: SM_CLEAR};
        scan_limit    = SW'(OWNER_ENTRIES);
        used_we       = 1'b0;
        used_waddr    = r_q;
        used_wdata    = 1'b0;
        valid_we      = 1'b0;
        valid_waddr   = scan_idx[OAW-1:0];
        valid_wdata   = 1'b0;
        own_we        = 1'b0;
        own_wdata     = {r_client, r_q};

        unique case (r_state)
            ST_INIT: begin
                scan_ctl = '{start: 1'b1, mode: SM_CLEAR};
            end
            ST_CLEAR: begin
                scan_limit  = SW'(MAXE);
                used_waddr  = scan_addr[UAW-1:0];
                valid_waddr = scan_addr[OAW-1:0];
                used_we     = scan_sts.issue && (scan_addr < SW'(QUEUE_SLOTS));
                valid_we    = scan_sts.issue && (scan_addr < SW'(OWNER_ENTRIES));
            end
            ST_IDLE: begin
                n_client = i_client_id;
                n_qin    = i_queue_id;
                if (start) begin
                    unique case (kind)
                        KIND_GET: begin
                            scan_ctl = '{start: 1'b1, mode: SM_FREE_Q};
                        end
                        KIND_FREE: begin
                            if (qin_ok) begin
                                used_we    = 1'b1;
                                used_waddr = UAW'(i_queue_id);
                                scan_ctl   = '{start: 1'b1, mode: SM_FIND};
                            end else begin
                                n_strobe = 1'b1;
                                n_status = STS_NO_QUEUE;
                            end
                        end
                        KIND_DISC: begin
                            scan_ctl = '{start: 1'b1, mode: SM_FIND};
                        end
                        KIND_QUERY: begin
                            // bitmap read issued below through used_raddr
                        end
                    endcase
                end
            end
            ST_GET_Q: begin
                scan_limit = lim;
                if (scan_sts.done) begin
                    if (scan_sts.found) begin
                        n_q      = scan_idx[UAW-1:0];
                        scan_ctl = '{start: 1'b1, mode: SM_FREE_SLOT};
                    end else begin
                        n_strobe = 1'b1;
                        n_status = STS_NO_QUEUE;
                    end
                end
            end
            ST_GET_SLOT: begin
                if (scan_sts.done) begin
                    if (scan_sts.found) begin
                        used_we     = 1'b1;
                        used_wdata  = 1'b1;
                        valid_we    = 1'b1;
                        valid_wdata = 1'b1;
                        own_we      = 1'b1;
                        n_strobe    = 1'b1;
                        n_qout      = QID_W'(r_q);
                    end else begin
                        // table full: queue is never marked, drop client's entry
                        scan_ctl = '{start: 1'b1, mode: SM_FIND};
                    end
                end
            end
            ST_GET_FIND: begin
                if (scan_sts.done) begin
                    valid_we = scan_sts.found;
                    n_strobe = 1'b1;
                    n_status = STS_TABLE_FULL;
                end
            end
            ST_FREE_FIND: begin
                if (scan_sts.done) begin
                    valid_we = scan_sts.found;
                    n_strobe = 1'b1;
                    n_status = scan_sts.found ? STS_OK : STS_NOT_FOUND;
                end
            end
            ST_DISC_FIND: begin
                if (scan_sts.done) begin
                    n_strobe = 1'b1;
                    if (scan_sts.found) begin
                        // owner word of the matching entry is on own_rd now
                        used_we    = own_q_ok;
                        used_waddr = own_q;
                        valid_we   = 1'b1;
                        n_qout     = QID_W'(own_q);
                    end else begin
                        n_status = STS_NOT_FOUND;
                    end
                end
            end
            ST_QRY_DATA: begin
                n_strobe = 1'b1;
                n_used   = used_rd && rqin_ok;
            end
            default: begin
            end
        endcase
    end

    assign used_raddr = (r_state == ST_IDLE) ? UAW'(i_queue_id) : scan_addr[UAW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_client <= n_client;
        r_qin    <= n_qin;
        r_q      <= n_q;
        r_status <= n_status;
        r_qout   <= n_qout;
        r_used   <= n_used;
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_queue_id_out = r_qout;
    assign o_used         = r_used;

    qida_scan #(
        .ADDR_W(SW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_limit     (scan_limit),
        .i_used_bit  (used_rd),
        .i_valid_bit (valid_rd),
        .i_client_rd (own_rd[OW-1:UAW]),
        .i_client_key(r_client),
        .o_sts       (scan_sts),
        .o_addr      (scan_addr),
        .o_idx       (scan_idx)
    );

    qida_ram #(
        .WIDTH(1),
        .DEPTH(QUEUE_SLOTS)
    ) u_used_ram (
        .i_clk  (i_clk),
        .i_we   (used_we),
        .i_waddr(used_waddr),
        .i_wdata(used_wdata),
        .i_raddr(used_raddr),
        .o_rdata(used_rd)
    );

    qida_ram #(
        .WIDTH(1),
        .DEPTH(OWNER_ENTRIES)
    ) u_valid_ram (
        .i_clk  (i_clk),
        .i_we   (valid_we),
        .i_waddr(valid_waddr),
        .i_wdata(valid_wdata),
        .i_raddr(scan_addr[OAW-1:0]),
        .o_rdata(valid_rd)
    );

    qida_ram #(
        .WIDTH(OW),
        .DEPTH(OWNER_ENTRIES)
    ) u_owner_ram (
        .i_clk  (i_clk),
        .i_we   (own_we),
        .i_waddr(valid_waddr),
        .i_wdata(own_wdata),
        .i_raddr(scan_addr[OAW-1:0]),
        .o_rdata(own_rd)
    );

    `QIDA_ASSERT_NOW(a_strobe_idle, o_strobe, r_state == ST_IDLE, "result word outside idle")
    `QIDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy || o_strobe, "word accepted but no work")
    `QIDA_ASSERT_NOW(a_full_no_qid, o_strobe && (o_status != STS_OK), o_queue_id_out == '0,
        "failed request returned a queue")
    `QIDA_ASSERT_NOW(a_used_ok, o_strobe && o_used, o_status == STS_OK, "used flag with error")
    `QIDA_ASSERT_NOW(a_scan_run, scan_sts.done, busy, "scan finished while idle")

endmodule

### tb/tb_queue_id_allocator_with_owner_map.sv
module tb_queue_id_allocator_with_owner_map;
    timeunit 1ns;
    timeprecision 1ps;

    import qida_pkg::*;

    localparam int SLOTS       = 128;
    localparam int ENTRIES     = 128;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_WAIT  = 140;

    typedef struct {
        t_kind             kind;
        logic [CLIENT_W-1:0] client;
        logic [QID_W-1:0]    qid;
    } t_cmd_word;

    typedef struct {
        t_status          status;
        logic [QID_W-1:0] qid;
        logic             used;
    } t_res_word;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic [1:0]          i_kind      = '0;
    logic [CLIENT_W-1:0] i_client_id = '0;
    logic [QID_W-1:0]    i_queue_id  = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [QCNT_W-1:0]   i_cfg_data  = '0;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic [QID_W-1:0]    o_queue_id_out;
    logic                o_used;

    queue_id_allocator_with_owner_map #(
        .QUEUE_SLOTS   (SLOTS),
        .OWNER_ENTRIES (ENTRIES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_client_id    (i_client_id),
        .i_queue_id     (i_queue_id),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_queue_id_out (o_queue_id_out),
        .o_used         (o_used)
    );

    always #5 i_clk = ~i_clk;

    // allocator shadow state
    logic [QCNT_W-1:0]   m_qcount = '0;
    bit                  m_used   [SLOTS];
    bit                  m_valid  [ENTRIES];
    logic [CLIENT_W-1:0] m_client [ENTRIES];
    logic [QID_W-1:0]    m_queue  [ENTRIES];

    t_cmd_word pending_cmds[$];
    t_res_word results_due[$];
    t_cmd_word drv_word;
    t_res_word want;
    logic [CLIENT_W-1:0] client_pool[8];

    int fail_count  = 0;
    int cycle_count = 0;
    int burst_left  = 8;
    int gap_left    = 0;

    function automatic int find_owner(logic [CLIENT_W-1:0] client);
        for (int i = 0; i < ENTRIES; i++) begin
            if (m_valid[i] && m_client[i] == client) return i;
        end
        return -1;
    endfunction

    function automatic int active_queues();
        return (m_qcount > SLOTS) ? SLOTS : int'(m_qcount);
    endfunction

    function automatic t_res_word alloc_predict(t_cmd_word w);
        t_res_word r;
        int lim;
        int q;
        int slot;
        int e;
        r.status = STS_OK;
        r.qid    = '0;
        r.used   = 1'b0;
        lim      = active_queues();
        case (w.kind)
            KIND_GET: begin
                q = -1;
                for (int i = 0; i < lim; i++) begin
                    if (!m_used[i]) begin
                        q = i;
                        break;
                    end
                end
                if (q < 0) begin
                    r.status = STS_NO_QUEUE;
                end else begin
                    slot = -1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!m_valid[i]) begin
                            slot = i;
                            break;
                        end
                    end
                    if (slot < 0) begin
                        // queue goes back, client's first entry is dropped
                        e = find_owner(w.client);
                        if (e >= 0) m_valid[e] = 1'b0;
                        r.status = STS_TABLE_FULL;
                    end else begin
                        m_used[q]      = 1'b1;
                        m_valid[slot]  = 1'b1;
                        m_client[slot] = w.client;
                        m_queue[slot]  = QID_W'(q);
                        r.qid          = QID_W'(q);
                    end
                end
            end
            KIND_FREE: begin
                if (w.qid >= lim) begin
                    r.status = STS_NO_QUEUE;
                end else begin
                    m_used[w.qid] = 1'b0;
                    e = find_owner(w.client);
                    if (e < 0) r.status = STS_NOT_FOUND;
                    else m_valid[e] = 1'b0;
                end
            end
            KIND_DISC: begin
                e = find_owner(w.client);
                if (e < 0) begin
                    r.status = STS_NOT_FOUND;
                end else begin
                    // bitmap untouched if the count was lowered below the queue
                    if (m_queue[e] < lim) m_used[m_queue[e]] = 1'b0;
                    m_valid[e] = 1'b0;
                    r.qid      = m_queue[e];
                end
            end
            default: begin
                if (w.qid < lim) r.used = m_used[w.qid];
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 5);
        return $urandom_range(6, 150);
    endfunction

    // command driver: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // hold the word until it is taken
        end else begin
            if (start) begin
                results_due.push_back(alloc_predict(drv_word));
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = pick_gap();
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                drv_word = pending_cmds.pop_front();
                start       <= 1'b1;
                i_kind      <= drv_word.kind;
                i_client_id <= drv_word.client;
                i_queue_id  <= drv_word.qid;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (results_due.size() == 0) begin
                $error("result word with none expected");
                fail_count++;
            end else begin
                want = results_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_queue_id_out !== want.qid) begin
                    $error("queue_id_out: expected %0d, got %0d", want.qid, o_queue_id_out);
                    fail_count++;
                end
                if (o_used !== want.used) begin
                    $error("used: expected %0d, got %0d", want.used, o_used);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_word(t_kind kind, logic [CLIENT_W-1:0] client, logic [QID_W-1:0] qid);
        t_cmd_word w;
        w.kind   = kind;
        w.client = client;
        w.qid    = qid;
        pending_cmds.push_back(w);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || start || results_due.size() != 0 || busy);
    endtask

    task automatic write_qcount(logic [QCNT_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        m_qcount = value;
        @(negedge i_clk);
    endtask

    task automatic run_mix(int n, int w_get, int w_free, int w_disc, int pool_pct);
        t_cmd_word w;
        int roll;
        int lim;
        lim = active_queues();
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < w_get) w.kind = KIND_GET;
            else if (roll < w_get + w_free) w.kind = KIND_FREE;
            else if (roll < w_get + w_free + w_disc) w.kind = KIND_DISC;
            else w.kind = KIND_QUERY;
            if ($urandom_range(0, 99) < pool_pct) w.client = client_pool[$urandom_range(0, 7)];
            else w.client = CLIENT_W'($urandom);
            if (lim > 0 && $urandom_range(0, 9) < 8) w.qid = QID_W'($urandom_range(0, lim - 1));
            else w.qid = QID_W'($urandom);
            pending_cmds.push_back(w);
        end
    endtask

    initial begin
        client_pool[0] = '0;
        client_pool[1] = '1;
        for (int i = 2; i < 8; i++) client_pool[i] = CLIENT_W'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(negedge i_clk);
        wait_drained();

        // nothing available with the count at its reset value
        add_word(KIND_GET, '0, QID_W'($urandom));
        add_word(KIND_FREE, '0, '0);
        add_word(KIND_QUERY, '1, '1);
        add_word(KIND_DISC, '0, QID_W'($urandom));

        write_qcount(8'd128);
        add_word(KIND_GET, '0, '1);
        add_word(KIND_GET, '1, '0);
        add_word(KIND_GET, '0, QID_W'($urandom));            // duplicate client
        add_word(KIND_QUERY, CLIENT_W'($urandom), 7'd1);
        add_word(KIND_QUERY, CLIENT_W'($urandom), '1);
        add_word(KIND_FREE, '0, '0);
        add_word(KIND_DISC, '0, QID_W'($urandom));
        add_word(KIND_DISC, '0, QID_W'($urandom));           // no entry left
        add_word(KIND_FREE, 31'h2AAA_AAAA, '1);               // unknown client, bit still cleared
        add_word(KIND_GET, 31'h5555_5555, QID_W'($urandom));
        add_word(KIND_QUERY, CLIENT_W'($urandom), '0);

        // lowered count: disconnect of a queue now out of range
        write_qcount(8'd1);
        add_word(KIND_DISC, '1, QID_W'($urandom));
        add_word(KIND_QUERY, CLIENT_W'($urandom), 7'd1);
        add_word(KIND_FREE, 31'h5555_5555, 7'd1);
        add_word(KIND_GET, 31'd1, QID_W'($urandom));
        add_word(KIND_FREE, 31'h5555_5555, '0);
        add_word(KIND_GET, 31'd1, QID_W'($urandom));

        // fill the owner table, then frees of unknown clients open queues
        // so that later gets run into a full table
        write_qcount(8'd128);
        repeat (130) add_word(KIND_GET, client_pool[$urandom_range(0, 7)], QID_W'($urandom));
        run_mix(220, 60, 35, 0, 20);

        write_qcount(8'd255);
        run_mix(200, 35, 20, 30, 70);

        write_qcount(8'd0);
        run_mix(60, 30, 25, 30, 70);

        write_qcount(8'd3);
        run_mix(150, 40, 20, 25, 80);

        write_qcount(QCNT_W'($urandom_range(4, 127)));
        run_mix(200, 40, 20, 25, 70);

        write_qcount(8'd128);
        run_mix(200, 45, 15, 25, 60);

        write_qcount(8'd2);
        run_mix(100, 40, 20, 25, 80);

        write_qcount(QCNT_W'($urandom_range(129, 254)));
        run_mix(100, 40, 20, 25, 60);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/qida_pkg.sv
src/qida_ram.sv
src/qida_scan.sv
src/queue_id_allocator_with_owner_map.sv
tb/tb_queue_id_allocator_with_owner_map.sv
